>>> hdl/thar_pkg.sv
// ----------------------------------------------------------------------------
// Threshold AR residual filter package
// Shared types, register indexes, reset values and numeric limits.
// ----------------------------------------------------------------------------
package thar_pkg;

  typedef enum logic [1:0] {
    REGIME_NONE = 2'd0,
    REGIME_LOW  = 2'd1,
    REGIME_HIGH = 2'd2
  } regime_e;

  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 48;
  localparam int CoefWidth    = 16;
  localparam int FracBits     = 12;
  localparam int AccWidth     = 48;
  localparam int CountWidth   = 16;
  localparam int SeenWidth    = 4;

  localparam logic [CfgIdxWidth-1:0] CFG_THRESHOLD   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_DELAY       = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_ORDER_LOW   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_ORDER_HIGH  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_COEFFS_LOW  = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CFG_COEFFS_HIGH = 3'd5;

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [AccWidth-1:0]   ACC_MAX   = {AccWidth{1'b1}};
  localparam logic [CountWidth-1:0] COUNT_MAX = {CountWidth{1'b1}};
  localparam logic [SeenWidth-1:0]  SEEN_MAX  = {SeenWidth{1'b1}};

  typedef struct packed {
    logic signed [15:0] threshold;
    logic [2:0]         delay;
    logic [1:0]         order_low;
    logic [1:0]         order_high;
    logic [47:0]        coeffs_low;
    logic [47:0]        coeffs_high;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    threshold:   16'sd5722,
    delay:       3'd2,
    order_low:   2'd2,
    order_high:  2'd1,
    coeffs_low:  48'd279503655996524,
    coeffs_high: 48'd104407384
  };

  typedef struct packed {
    logic restart;
    logic active;
    logic low;
  } job_ctrl_t;

  typedef struct packed {
    logic signed [CoefWidth-1:0] c2;
    logic signed [CoefWidth-1:0] c1;
    logic signed [CoefWidth-1:0] icpt;
  } coef_t;

endpackage

>>> hdl/thar_if.sv
// ----------------------------------------------------------------------------
// Threshold AR residual filter channels
// Valid/ready channels for the sample words and the result words.
// ----------------------------------------------------------------------------
interface thar_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink (input valid, input op, input sample, output ready);
endinterface

interface thar_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     regime;
  logic signed [SAMPLE_WIDTH-1:0] fitted;
  logic signed [SAMPLE_WIDTH-1:0] residual;
  logic [47:0]                    sumsq_low;
  logic [47:0]                    sumsq_high;
  logic [15:0]                    count_low;
  logic [15:0]                    count_high;

  modport source (
    output valid, output regime, output fitted, output residual,
    output sumsq_low, output sumsq_high, output count_low, output count_high,
    input ready
  );
  modport sink (
    input valid, input regime, input fitted, input residual,
    input sumsq_low, input sumsq_high, input count_low, input count_high,
    output ready
  );
endinterface

>>> hdl/thar_queue.sv
// ----------------------------------------------------------------------------
// Threshold AR residual filter job queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module thar_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntWidth = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;

  function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] ptr);
    if (ptr == PtrWidth'(DEPTH - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

  assign full_o  = (count_q == CntWidth'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntWidth'(push_i) - CntWidth'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end
endmodule

>>> hdl/thar_front.sv
// ----------------------------------------------------------------------------
// Threshold AR residual filter front end
// Accepts sample words, keeps the history and picks the regime and taps.
// ----------------------------------------------------------------------------
module thar_front #(
  parameter int HISTORY_DEPTH = 8,
  parameter int MAX_ORDER     = 2,
  parameter int SAMPLE_WIDTH  = 16,
  localparam int JobWidth = $bits(thar_pkg::job_ctrl_t) + $bits(thar_pkg::coef_t)
                            + 3 * SAMPLE_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  thar_pkg::cfg_t      cfg_i,
  thar_in_if.sink             in_i,
  input  logic                q_full_i,
  output logic                push_o,
  output logic [JobWidth-1:0] job_o
);
  import thar_pkg::*;

  localparam int CmpWidth = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;

  logic signed [SAMPLE_WIDTH-1:0] hist_q [HISTORY_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] hist_d [HISTORY_DEPTH];
  logic [SeenWidth-1:0]           seen_q, seen_d;

  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [SAMPLE_WIDTH-1:0] past;
  logic                           low;
  logic                           delay_ok;
  logic [1:0]                     ord;
  logic [47:0]                    cf;
  job_ctrl_t                      ctrl;
  coef_t                          coef;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;
  assign x          = in_i.sample;

  always_comb begin
    past = x;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (32'(cfg_i.delay) == i + 1) begin
        past = hist_q[i];
      end
    end
    delay_ok = (32'(cfg_i.delay) <= HISTORY_DEPTH);
    low      = $signed(CmpWidth'(past)) <= $signed(CmpWidth'(cfg_i.threshold));
    ord      = low ? cfg_i.order_low : cfg_i.order_high;
    cf       = low ? cfg_i.coeffs_low : cfg_i.coeffs_high;

    ctrl.restart = (in_i.op == OP_RESTART);
    ctrl.active  = delay_ok && (seen_q >= {1'b0, cfg_i.delay})
                   && (seen_q >= {2'b00, ord});
    ctrl.low     = low;

    coef.icpt = cf[15:0];
    coef.c1   = ((ord >= 2'd1) && (MAX_ORDER >= 1)) ? cf[31:16] : '0;
    coef.c2   = ((ord >= 2'd2) && (MAX_ORDER >= 2)) ? cf[47:32] : '0;
  end

  assign job_o = {ctrl, coef, x, hist_q[0], hist_q[1]};

  always_comb begin
    hist_d = hist_q;
    seen_d = seen_q;
    if (push_o) begin
      if (ctrl.restart) begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
          hist_d[i] = '0;
        end
        seen_d = '0;
      end else begin
        for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
          hist_d[i] = hist_q[i-1];
        end
        hist_d[0] = x;
        if (seen_q != SEEN_MAX) begin
          seen_d = seen_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
      seen_q <= '0;
    end else begin
      hist_q <= hist_d;
      seen_q <= seen_d;
    end
  end
endmodule

>>> hdl/thar_back.sv
// ----------------------------------------------------------------------------
// Threshold AR residual filter back end
// Sequencer that forms the fitted value, the residual and the regime totals.
// ----------------------------------------------------------------------------
module thar_back #(
  parameter int SAMPLE_WIDTH = 16,
  localparam int JobWidth = $bits(thar_pkg::job_ctrl_t) + $bits(thar_pkg::coef_t)
                            + 3 * SAMPLE_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  logic [JobWidth-1:0] job_i,
  output logic                pop_o,
  thar_out_if.source          out_o
);
  import thar_pkg::*;

  localparam int SW       = SAMPLE_WIDTH;
  localparam int ProdWidth = CoefWidth + SW;
  localparam int SumWidth = ((ProdWidth > CoefWidth + FracBits) ? ProdWidth
                             : CoefWidth + FracBits) + 2;
  localparam int RndWidth = SumWidth - FracBits;
  localparam int SqWidth  = 2 * SW;
  localparam int AddWidth = ((SqWidth > AccWidth) ? SqWidth : AccWidth) + 1;
  localparam logic signed [RndWidth-1:0] SatHi = {{(RndWidth-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [RndWidth-1:0] SatLo = ~SatHi;
  localparam logic signed [SumWidth-1:0] RoundBias = SumWidth'(1) <<< (FracBits - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_FIT  = 6'b000100,
    ST_RES  = 6'b001000,
    ST_SQ   = 6'b010000,
    ST_ACC  = 6'b100000
  } state_e;

  state_e                      state_q, state_d;
  job_ctrl_t                   ctrl_q, job_ctrl;
  coef_t                       coef_q, job_coef;
  logic signed [SW-1:0]        x_q, lag1_q, lag2_q;
  logic signed [SW-1:0]        job_x, job_lag1, job_lag2;
  logic signed [ProdWidth-1:0] p1_q, p2_q;
  logic signed [SW-1:0]        fit_q, res_q;
  logic [SqWidth-1:0]          sq_q;
  logic [AccWidth-1:0]         acc_low_q, acc_low_d, acc_high_q, acc_high_d;
  logic [CountWidth-1:0]       num_low_q, num_low_d, num_high_q, num_high_d;

  logic signed [SumWidth-1:0]  sum;
  logic signed [RndWidth-1:0]  rnd;
  logic signed [SW-1:0]        fit_d;
  logic signed [SW:0]          diff;
  logic signed [SW-1:0]        res_d;
  logic signed [SqWidth-1:0]   sq_s;
  logic [AddWidth-1:0]         add_low, add_high;
  logic [AccWidth-1:0]         sat_low, sat_high;
  logic                        load;

  logic                        out_valid_q;
  regime_e                     regime_q, regime_d;
  logic signed [SW-1:0]        out_fit_q, out_fit_d, out_res_q, out_res_d;
  logic [AccWidth-1:0]         out_sl_q, out_sh_q;
  logic [CountWidth-1:0]       out_cl_q, out_ch_q;

  assign {job_ctrl, job_coef, job_x, job_lag1, job_lag2} = job_i;

  assign pop_o = (state_q == ST_IDLE) && q_valid_i;
  assign load  = (state_q == ST_ACC) && (!out_valid_q || out_o.ready);

  always_comb begin
    sum = ($signed(SumWidth'(coef_q.icpt)) <<< FracBits) + SumWidth'(p1_q)
          + SumWidth'(p2_q) + RoundBias;
    rnd = sum[SumWidth-1:FracBits];
    if (rnd > SatHi) begin
      fit_d = SatHi[SW-1:0];
    end else if (rnd < SatLo) begin
      fit_d = SatLo[SW-1:0];
    end else begin
      fit_d = rnd[SW-1:0];
    end

    diff = (SW+1)'(x_q) - (SW+1)'(fit_q);
    if (diff[SW] != diff[SW-1]) begin
      res_d = diff[SW] ? SatLo[SW-1:0] : SatHi[SW-1:0];
    end else begin
      res_d = diff[SW-1:0];
    end

    sq_s = res_q * res_q;

    add_low  = AddWidth'(acc_low_q) + AddWidth'(sq_q);
    add_high = AddWidth'(acc_high_q) + AddWidth'(sq_q);
    sat_low  = (add_low[AddWidth-1:AccWidth] != '0) ? ACC_MAX : add_low[AccWidth-1:0];
    sat_high = (add_high[AddWidth-1:AccWidth] != '0) ? ACC_MAX : add_high[AccWidth-1:0];
  end

  always_comb begin
    acc_low_d  = acc_low_q;
    acc_high_d = acc_high_q;
    num_low_d  = num_low_q;
    num_high_d = num_high_q;
    regime_d   = REGIME_NONE;
    out_fit_d  = '0;
    out_res_d  = '0;
    if (ctrl_q.restart) begin
      acc_low_d  = '0;
      acc_high_d = '0;
      num_low_d  = '0;
      num_high_d = '0;
    end else if (ctrl_q.active) begin
      out_fit_d = fit_q;
      out_res_d = res_q;
      if (ctrl_q.low) begin
        regime_d  = REGIME_LOW;
        acc_low_d = sat_low;
        if (num_low_q != COUNT_MAX) begin
          num_low_d = num_low_q + 1'b1;
        end
      end else begin
        regime_d   = REGIME_HIGH;
        acc_high_d = sat_high;
        if (num_high_q != COUNT_MAX) begin
          num_high_d = num_high_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (state_q)
      ST_IDLE: state_d = q_valid_i ? ST_MUL : ST_IDLE;
      ST_MUL:  state_d = ST_FIT;
      ST_FIT:  state_d = ST_RES;
      ST_RES:  state_d = ST_SQ;
      ST_SQ:   state_d = ST_ACC;
      ST_ACC:  state_d = load ? ST_IDLE : ST_ACC;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      acc_low_q   <= '0;
      acc_high_q  <= '0;
      num_low_q   <= '0;
      num_high_q  <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
        acc_low_q   <= acc_low_d;
        acc_high_q  <= acc_high_d;
        num_low_q   <= num_low_d;
        num_high_q  <= num_high_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ctrl_q <= job_ctrl;
      coef_q <= job_coef;
      x_q    <= job_x;
      lag1_q <= job_lag1;
      lag2_q <= job_lag2;
    end
    if (state_q == ST_MUL) begin
      p1_q <= $signed(coef_q.c1) * lag1_q;
      p2_q <= $signed(coef_q.c2) * lag2_q;
    end
    if (state_q == ST_FIT) begin
      fit_q <= fit_d;
    end
    if (state_q == ST_RES) begin
      res_q <= res_d;
    end
    if (state_q == ST_SQ) begin
      sq_q <= sq_s;
    end
    if (load) begin
      regime_q  <= regime_d;
      out_fit_q <= out_fit_d;
      out_res_q <= out_res_d;
      out_sl_q  <= acc_low_d;
      out_sh_q  <= acc_high_d;
      out_cl_q  <= num_low_d;
      out_ch_q  <= num_high_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.regime     = regime_q;
  assign out_o.fitted     = out_fit_q;
  assign out_o.residual   = out_res_q;
  assign out_o.sumsq_low  = out_sl_q;
  assign out_o.sumsq_high = out_sh_q;
  assign out_o.count_low  = out_cl_q;
  assign out_o.count_high = out_ch_q;
endmodule

>>> hdl/threshold_ar_residual_filter_top.sv
// ----------------------------------------------------------------------------
// Threshold AR residual filter top level
// Two-regime threshold AR filter giving fitted values, residuals and totals.
// ----------------------------------------------------------------------------
//   Port      Dir  Words
//   in_i      in   op, sample
//   out_o     out  regime, fitted, residual, sumsq_low/high, count_low/high
//   cfg_*     in   register writes, index and 48-bit data
//
// The back end works on one word at a time through its multiply, fit, residual,
// square and accumulate states, and it pops the next word only from idle.
// A result is registered when the accumulate state finds the output register free.
// The front end keeps taking words into a two-entry queue, until it is full, while
// the back end works or waits for the output register to be taken.
// Reset loads the register defaults and clears the history and the totals.
// ----------------------------------------------------------------------------
module threshold_ar_residual_filter_top #(
  parameter int HISTORY_DEPTH = 8,
  parameter int MAX_ORDER     = 2,
  parameter int SAMPLE_WIDTH  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  thar_in_if.sink                              in_i,
  thar_out_if.source                           out_o,
  input  logic                                 cfg_we_i,
  input  logic [thar_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [thar_pkg::CfgDataWidth-1:0]    cfg_data_i
);
  import thar_pkg::*;

  localparam int JobWidth = $bits(job_ctrl_t) + $bits(coef_t) + 3 * SAMPLE_WIDTH;
  localparam int QueueDepth = 2;

  cfg_t                cfg_q;
  logic                q_full;
  logic                q_valid;
  logic                push;
  logic                pop;
  logic [JobWidth-1:0] job_in;
  logic [JobWidth-1:0] job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD:   cfg_q.threshold   <= cfg_data_i[15:0];
        CFG_DELAY:       cfg_q.delay       <= cfg_data_i[2:0];
        CFG_ORDER_LOW:   cfg_q.order_low   <= cfg_data_i[1:0];
        CFG_ORDER_HIGH:  cfg_q.order_high  <= cfg_data_i[1:0];
        CFG_COEFFS_LOW:  cfg_q.coeffs_low  <= cfg_data_i[47:0];
        CFG_COEFFS_HIGH: cfg_q.coeffs_high <= cfg_data_i[47:0];
        default: begin
        end
      endcase
    end
  end

  thar_front #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .MAX_ORDER    (MAX_ORDER),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .in_i    (in_i),
    .q_full_i(q_full),
    .push_o  (push),
    .job_o   (job_in)
  );

  thar_queue #(
    .WIDTH(JobWidth),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (job_out)
  );

  thar_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .job_i    (job_out),
    .pop_o    (pop),
    .out_o    (out_o)
  );
endmodule

>>> hdl/thar_checker.sv
// ----------------------------------------------------------------------------
// Threshold AR residual filter checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module thar_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [1:0]              regime_i,
  input logic [SAMPLE_WIDTH-1:0] fitted_i,
  input logic [SAMPLE_WIDTH-1:0] residual_i,
  input logic [47:0]             sumsq_low_i,
  input logic [47:0]             sumsq_high_i,
  input logic [15:0]             count_low_i,
  input logic [15:0]             count_high_i
);
  import thar_pkg::*;

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result word dropped while stalled.");

  a_warmup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (regime_i == REGIME_NONE) |-> (fitted_i == '0) && (residual_i == '0))
    else $error("Result without regime carries a nonzero fit or residual.");

  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((count_low_i != '0) || (sumsq_low_i == '0))
                 && ((count_high_i != '0) || (sumsq_high_i == '0)))
    else $error("Sum of squares is nonzero with a zero count.");

  a_regime_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((regime_i != REGIME_LOW) || (count_low_i != '0))
                 && ((regime_i != REGIME_HIGH) || (count_high_i != '0)))
    else $error("Regime result given with a zero count for that regime.");
endmodule

bind threshold_ar_residual_filter_top thar_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_thar_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .regime_i    (out_o.regime),
  .fitted_i    (out_o.fitted),
  .residual_i  (out_o.residual),
  .sumsq_low_i (out_o.sumsq_low),
  .sumsq_high_i(out_o.sumsq_high),
  .count_low_i (out_o.count_low),
  .count_high_i(out_o.count_high)
);
